[rtl/mnc_pkg.sv]
package mnc_pkg;

  // Fixed field widths
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned SEL_W   = 16;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned CNT_W   = 25;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned ROW_LIMIT = 4096;
  localparam int unsigned OUT_W   = 80;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_SELECT  = 2'd2;

  // Pixel classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_GOOD0  = 4'd0,
    CLS_GOOD1  = 4'd1,
    CLS_GOOD2  = 4'd2,
    CLS_CENTER = 4'd3,
    CLS_C_MXMY = 4'd4,
    CLS_C_MXPY = 4'd5,
    CLS_C_PXMY = 4'd6,
    CLS_C_PXPY = 4'd7,
    CLS_BAD    = 4'd8
  } class_e;

  // One result item; class_code sits in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]   bad_total;
    logic [CNT_W-1:0]   poor_total;
    logic               frame_done;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [CLASS_W-1:0] class_code;
  } res_t;

  // 3x3 neighborhood of window position (cx,cy); bit (dy+1)*3+(dx+1), outside reads 0
  function automatic logic [8:0] nbhd(logic [8:0] bits, int cx, int cy);
    logic [8:0] nb;
    int x;
    int y;
    nb = '0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        x = cx + dx;
        y = cy + dy;
        if (x >= 0 && x <= 2 && y >= 0 && y <= 2) begin
          nb[(dy + 1) * 3 + dx + 1] = bits[y * 3 + x];
        end
      end
    end
    return nb;
  endfunction

  // Class of the center of a neighborhood
  function automatic logic [CLASS_W-1:0] classify(logic [8:0] nb);
    logic [3:0] n;
    logic       left;
    logic       right;
    logic       up;
    logic       down;
    logic [CLASS_W-1:0] code;
    n = '0;
    for (int k = 0; k < 9; k++) begin
      n = n + 4'(nb[k]);
    end
    left  = nb[0] | nb[3] | nb[6];
    right = nb[2] | nb[5] | nb[8];
    up    = nb[0] | nb[1] | nb[2];
    down  = nb[6] | nb[7] | nb[8];
    if (nb[4]) begin
      if (n >= 4'd6 && left && right && up && down) code = CLS_GOOD2;
      else if (n >= 4'd3)                           code = CLS_GOOD1;
      else                                          code = CLS_GOOD0;
    end else begin
      if (n >= 4'd6)                      code = CLS_CENTER;
      else if (nb[0] && nb[1] && nb[3])   code = CLS_C_MXMY;
      else if (nb[3] && nb[6] && nb[7])   code = CLS_C_MXPY;
      else if (nb[1] && nb[2] && nb[5])   code = CLS_C_PXMY;
      else if (nb[5] && nb[7] && nb[8])   code = CLS_C_PXPY;
      else                                code = CLS_BAD;
    end
    return code;
  endfunction

  // Count plus a small increment, held at the top
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] base, logic [2:0] k);
    logic [CNT_W:0] s;
    s = {1'b0, base} + (CNT_W + 1)'(k);
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

[rtl/mask_neighborhood_classifier.sv]
// Mask neighborhood classifier. Mask words enter in raster order on the s_ side; a
// pixel is good when its word ANDed with mask_select is zero. Each pixel is classified
// from the good pixels of its 3x3 window inside the image, as soon as its lower-right
// neighbor has arrived (last row and last column without waiting), and leaves on the m_
// side as one result with its row, column and the running poor and bad counts of the
// frame; frame_done marks the last pixel. The block takes one pixel per cycle and sends
// one result per cycle unless stalled: most pixels release one result, a pixel at the
// end of a row releases two and pixels of the last row up to four, and the input waits
// while extra results go out. The stages are line-store read, classification and output
// register. Two rows of good bits are kept in two 1-bit line RAMs of MAX_WIDTH entries,
// read once per pixel; they need no clearing after reset. The user writes configuration
// only while the block is idle; the block itself does not enforce it.
module mask_neighborhood_classifier #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MASK_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [mnc_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel input
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [((MASK_BITS+7)/8)*8-1:0] s_tdata_i,  // mask_word
  // result output
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // class_code, pixel_row, pixel_col, frame_done, poor_total, bad_total
  output logic [mnc_pkg::OUT_W-1:0]     m_tdata_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned LW    = (COL_W + 1 > mnc_pkg::DIM_W) ? COL_W + 1 : mnc_pkg::DIM_W;
  localparam int unsigned PAD_W = mnc_pkg::OUT_W - $bits(mnc_pkg::res_t);

  // Configuration registers
  logic [mnc_pkg::DIM_W-1:0] frame_width_q;
  logic [mnc_pkg::DIM_W-1:0] frame_height_q;
  logic [mnc_pkg::SEL_W-1:0] mask_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mnc_pkg::DIM_W'(4096);
      frame_height_q <= mnc_pkg::DIM_W'(4096);
      mask_select_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[mnc_pkg::DIM_W-1:0];
        mnc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[mnc_pkg::DIM_W-1:0];
        mnc_pkg::REG_MASK_SELECT:  mask_select_q  <= cfg_data_i[mnc_pkg::SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [LW-1:0]            w_eff;
  logic [mnc_pkg::DIM_W-1:0] h_eff;
  logic [MASK_BITS-1:0]     sel_ext;

  always_comb begin
    if (frame_width_q == '0)                         w_eff = LW'(1);
    else if (LW'(frame_width_q) > LW'(MAX_WIDTH))    w_eff = LW'(MAX_WIDTH);
    else                                             w_eff = LW'(frame_width_q);
    if (frame_height_q == '0)                                    h_eff = mnc_pkg::DIM_W'(1);
    else if (frame_height_q > mnc_pkg::DIM_W'(mnc_pkg::ROW_LIMIT))
      h_eff = mnc_pkg::DIM_W'(mnc_pkg::ROW_LIMIT);
    else                                                         h_eff = frame_height_q;
    for (int i = 0; i < MASK_BITS; i++) begin
      sel_ext[i] = (i < mnc_pkg::SEL_W) ? mask_select_q[i] : 1'b0;
    end
  end

  // Input position tracking
  logic                      s_xfer;
  logic [COL_W-1:0]          in_col_q;
  logic [mnc_pkg::PIX_W-1:0] in_row_q;
  logic                      end_col;
  logic                      last_row;
  logic                      in_good;

  assign s_xfer   = s_tvalid_i && s_tready_o;
  assign end_col  = (LW'(in_col_q) + LW'(1)) >= w_eff;
  assign last_row = ({1'b0, in_row_q} + mnc_pkg::DIM_W'(1)) >= h_eff;
  assign in_good  = (s_tdata_i[MASK_BITS-1:0] & sel_ext) == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (s_xfer) begin
      if (end_col) begin
        in_col_q <= '0;
        in_row_q <= last_row ? '0 : in_row_q + mnc_pkg::PIX_W'(1);
      end else begin
        in_col_q <= in_col_q + COL_W'(1);
      end
    end
  end

  // Classification stage register
  logic                      a_valid_q;
  logic                      a_adv;
  logic [COL_W-1:0]          a_col_q;
  logic [mnc_pkg::PIX_W-1:0] a_row_q;
  logic                      a_end_q;
  logic                      a_last_q;
  logic                      a_first_q;
  logic                      a_good_q;
  logic                      grp_free;

  assign a_adv      = a_valid_q && grp_free;
  assign s_tready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      a_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      a_col_q   <= in_col_q;
      a_row_q   <= in_row_q;
      a_end_q   <= end_col;
      a_last_q  <= last_row;
      a_first_q <= (in_row_q == '0) && (in_col_q == '0);
      a_good_q  <= in_good;
    end
  end

  // Line stores: row above and two rows above
  logic line_store_a_q [MAX_WIDTH];
  logic line_store_b_q [MAX_WIDTH];
  logic rd_a_q;
  logic rd_b_q;
  logic above;
  logic above2;

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      rd_a_q <= line_store_a_q[in_col_q];
      rd_b_q <= line_store_b_q[in_col_q];
    end
    if (a_adv) begin
      line_store_a_q[a_col_q] <= a_good_q;
      line_store_b_q[a_col_q] <= above;
    end
  end

  // Forward the write that lands on the same edge as a read of the same column
  logic byp_q;
  logic byp_a_q;
  logic byp_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (s_tready_o) begin
      byp_q <= s_xfer && a_adv && (in_col_q == a_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      byp_a_q <= a_good_q;
      byp_b_q <= above;
    end
  end

  assign above  = byp_q ? byp_a_q : rd_a_q;
  assign above2 = byp_q ? byp_b_q : rd_b_q;

  // Window update, classification and running counts
  logic [8:0]          win_q;
  logic [8:0]          win_d;
  logic [8:0]          win_bits;
  logic [2:0]          colv;
  logic [3:0]          emit;
  logic [3:0]          is_poor;
  logic [3:0]          is_bad;
  mnc_pkg::res_t       ent [4];
  logic [mnc_pkg::CLASS_W-1:0] code [4];
  logic [2:0]          pp;
  logic [2:0]          bp;
  logic [mnc_pkg::CNT_W-1:0] poor_q;
  logic [mnc_pkg::CNT_W-1:0] bad_q;
  logic [mnc_pkg::CNT_W-1:0] poor_base;
  logic [mnc_pkg::CNT_W-1:0] bad_base;
  logic [mnc_pkg::PIX_W-1:0] row_m1;
  logic [mnc_pkg::PIX_W-1:0] col_c;
  logic [mnc_pkg::PIX_W-1:0] col_m1;

  always_comb begin
    win_d = {a_good_q, win_q[8], win_q[7], above, win_q[5], win_q[4], above2,
             win_q[2], win_q[1]};
    colv  = {1'b1, a_col_q >= COL_W'(1), a_col_q >= COL_W'(2)};
    win_bits = win_d & {colv,
                        (a_row_q >= mnc_pkg::PIX_W'(1)) ? colv : 3'b000,
                        (a_row_q >= mnc_pkg::PIX_W'(2)) ? colv : 3'b000};

    emit[0] = (a_row_q != '0) && (a_col_q != '0);
    emit[1] = (a_row_q != '0) && a_end_q;
    emit[2] = a_last_q && (a_col_q != '0);
    emit[3] = a_last_q && a_end_q;

    code[0] = mnc_pkg::classify(mnc_pkg::nbhd(win_bits, 1, 1));
    code[1] = mnc_pkg::classify(mnc_pkg::nbhd(win_bits, 2, 1));
    code[2] = mnc_pkg::classify(mnc_pkg::nbhd(win_bits, 1, 2));
    code[3] = mnc_pkg::classify(mnc_pkg::nbhd(win_bits, 2, 2));

    row_m1 = a_row_q - mnc_pkg::PIX_W'(1);
    col_c  = mnc_pkg::PIX_W'(a_col_q);
    col_m1 = mnc_pkg::PIX_W'(a_col_q - COL_W'(1));

    poor_base = a_first_q ? '0 : poor_q;
    bad_base  = a_first_q ? '0 : bad_q;
    pp = '0;
    bp = '0;
    for (int i = 0; i < 4; i++) begin
      is_bad[i]  = emit[i] && (code[i] == mnc_pkg::CLS_BAD);
      is_poor[i] = emit[i] && (code[i] >= mnc_pkg::CLS_CENTER) &&
                   (code[i] != mnc_pkg::CLS_BAD);
      pp = pp + 3'(is_poor[i]);
      bp = bp + 3'(is_bad[i]);
      ent[i].class_code = code[i];
      ent[i].poor_total = mnc_pkg::sat_add(poor_base, pp);
      ent[i].bad_total  = mnc_pkg::sat_add(bad_base, bp);
      ent[i].frame_done = (i == 3);
    end
    ent[0].pixel_row = row_m1;  ent[0].pixel_col = col_m1;
    ent[1].pixel_row = row_m1;  ent[1].pixel_col = col_c;
    ent[2].pixel_row = a_row_q; ent[2].pixel_col = col_m1;
    ent[3].pixel_row = a_row_q; ent[3].pixel_col = col_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      poor_q <= '0;
      bad_q  <= '0;
    end else if (a_adv) begin
      win_q  <= win_d;
      poor_q <= ent[3].poor_total;
      bad_q  <= ent[3].bad_total;
    end
  end

  // Result group: up to four results of one pixel, sent lowest first
  logic [3:0]    grp_vld_q;
  mnc_pkg::res_t grp_q [4];
  logic [1:0]    front;
  logic          out_load;
  logic          pop;
  mnc_pkg::res_t out_q;
  logic          out_valid_q;

  always_comb begin
    front = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (grp_vld_q[i]) front = 2'(i);
    end
  end

  assign out_load = !out_valid_q || m_tready_i;
  assign pop      = (grp_vld_q != '0) && out_load;
  assign grp_free = (grp_vld_q == '0) ||
                    (pop && ((grp_vld_q & (grp_vld_q - 4'd1)) == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= '0;
    end else if (a_adv) begin
      grp_vld_q <= emit;
    end else if (pop) begin
      grp_vld_q[front] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      for (int i = 0; i < 4; i++) begin
        grp_q[i] <= ent[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= grp_q[front];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{PAD_W{1'b0}}, out_q};

  // Checks
  a_grp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_vld_q != '0) && !pop |=> grp_vld_q == $past(grp_vld_q))
    else $error("result group changed without a transfer");

  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> a_valid_q)
    else $error("accepted pixel did not reach the classification stage");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> out_q.class_code <= mnc_pkg::CLS_BAD)
    else $error("class code out of range");

  a_bypass_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> a_valid_q)
    else $error("forwarded line data without a pixel in the stage");

endmodule

[tb/mask_neighborhood_classifier_tb.sv]
module mask_neighborhood_classifier_tb;

  localparam int unsigned LINE_DEPTH    = 4096;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_PIXELS = 180;
  localparam int unsigned ROW_PIXELS    = 100;
  localparam int unsigned COLUMN_PIXELS = 40;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      cfg_we_i   = 1'b0;
  logic [1:0]                cfg_idx_i  = mnc_pkg::REG_FRAME_WIDTH;
  logic [mnc_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                      s_tvalid_i = 1'b0;
  logic                      s_tready_o;
  logic [15:0]               s_tdata_i  = '0;   // mask_word
  logic                      m_tvalid_o;
  logic                      m_tready_i = 1'b0;
  // class_code, pixel_row, pixel_col, frame_done, poor_total, bad_total
  logic [mnc_pkg::OUT_W-1:0] m_tdata_o;

  mask_neighborhood_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // Random bubbles on both sides; cleared for the long burst
  bit gaps_on = 1'b1;

  // Shadow of the classifier: line stores, window, position, frame counts, registers
  logic                      above_bits  [LINE_DEPTH];
  logic                      above2_bits [LINE_DEPTH];
  logic [8:0]                win_bits    = '0;
  int unsigned               next_row    = 0;
  int unsigned               next_col    = 0;
  logic [mnc_pkg::CNT_W-1:0] poor_run    = '0;
  logic [mnc_pkg::CNT_W-1:0] bad_run     = '0;
  int unsigned               frame_w     = 4096;
  int unsigned               frame_h     = 4096;
  logic [mnc_pkg::SEL_W-1:0] select_bits = '1;

  mnc_pkg::res_t pending_results [$];
  int unsigned   pixels_sent = 0;
  int unsigned   fail_count  = 0;
  int unsigned   cycle_count = 0;

  // Good bit of window cell (cx+dx, cy+dy); cells off the 3x3 grid read as masked
  function automatic bit win_at(logic [8:0] bits, int cx, int cy, int dx, int dy);
    int x;
    int y;
    x = cx + dx;
    y = cy + dy;
    if (x < 0 || x > 2 || y < 0 || y > 2) return 1'b0;
    return bits[y * 3 + x];
  endfunction

  // Good neighbors inside an offset rectangle, the center itself excluded
  function automatic int good_in_block(logic [8:0] bits, int cx, int cy,
                                       int x0, int x1, int y0, int y1);
    int n;
    n = 0;
    for (int dy = y0; dy <= y1; dy++) begin
      for (int dx = x0; dx <= x1; dx++) begin
        if (dx != 0 || dy != 0) n += win_at(bits, cx, cy, dx, dy);
      end
    end
    return n;
  endfunction

  function automatic mnc_pkg::class_e window_class(logic [8:0] bits, int cx, int cy);
    int n;
    bit lf;
    bit rt;
    bit up;
    bit dn;
    n = good_in_block(bits, cx, cy, -1, 1, -1, 1);
    if (win_at(bits, cx, cy, 0, 0)) begin
      lf = 0;
      rt = 0;
      up = 0;
      dn = 0;
      for (int k = -1; k <= 1; k++) begin
        lf |= win_at(bits, cx, cy, -1, k);
        rt |= win_at(bits, cx, cy, 1, k);
        up |= win_at(bits, cx, cy, k, -1);
        dn |= win_at(bits, cx, cy, k, 1);
      end
      if (n + 1 >= 6 && lf && rt && up && dn) return mnc_pkg::CLS_GOOD2;
      if (n + 1 >= 3) return mnc_pkg::CLS_GOOD1;
      return mnc_pkg::CLS_GOOD0;
    end
    // masked pixel: full ring first, then the corners in fixed order
    if (n >= 6) return mnc_pkg::CLS_CENTER;
    if (good_in_block(bits, cx, cy, -1, 0, -1, 0) >= 3) return mnc_pkg::CLS_C_MXMY;
    if (good_in_block(bits, cx, cy, -1, 0, 0, 1) >= 3) return mnc_pkg::CLS_C_MXPY;
    if (good_in_block(bits, cx, cy, 0, 1, -1, 0) >= 3) return mnc_pkg::CLS_C_PXMY;
    if (good_in_block(bits, cx, cy, 0, 1, 0, 1) >= 3) return mnc_pkg::CLS_C_PXPY;
    return mnc_pkg::CLS_BAD;
  endfunction

  function automatic void record_result(logic [8:0] bits, int cx, int cy,
                                        int unsigned row, int unsigned col, bit done);
    mnc_pkg::res_t   want;
    mnc_pkg::class_e code;
    code = window_class(bits, cx, cy);
    if (code == mnc_pkg::CLS_BAD) begin
      if (bad_run != mnc_pkg::COUNT_MAX) bad_run = bad_run + 1'b1;
    end else if (code >= mnc_pkg::CLS_CENTER) begin
      if (poor_run != mnc_pkg::COUNT_MAX) poor_run = poor_run + 1'b1;
    end
    want.class_code = code;
    want.pixel_row  = mnc_pkg::PIX_W'(row);
    want.pixel_col  = mnc_pkg::PIX_W'(col);
    want.frame_done = done;
    want.poor_total = poor_run;
    want.bad_total  = bad_run;
    pending_results.push_back(want);
  endfunction

  // Advance the shadow by one accepted pixel and queue the results it releases
  function automatic void classify_pixel(logic [15:0] word);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    bit          end_col;
    bit          last_row;
    logic        good;
    logic        above;
    logic        above2;
    logic [2:0]  col_ok;
    logic [8:0]  in_image;
    logic [8:0]  bits;
    w = (frame_w == 0) ? 1 : frame_w;
    h = (frame_h == 0) ? 1 : frame_h;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h > mnc_pkg::ROW_LIMIT) h = mnc_pkg::ROW_LIMIT;
    r = next_row;
    c = (next_col < LINE_DEPTH) ? next_col : LINE_DEPTH - 1;
    end_col  = (c + 1 >= w);
    last_row = (r + 1 >= h);
    if (r == 0 && c == 0) begin
      poor_run = '0;
      bad_run  = '0;
    end
    good   = ((word & select_bits) == '0);
    above  = above_bits[c];
    above2 = above2_bits[c];
    win_bits = ((win_bits >> 1) & 9'h0DB) | (9'(above2) << 2) | (9'(above) << 5)
             | (9'(good) << 8);
    above2_bits[c] = above;
    above_bits[c]  = good;
    // only window cells inside the image take part
    col_ok   = {1'b1, c >= 1, c >= 2};
    in_image = {col_ok, (r >= 1) ? col_ok : 3'b000, (r >= 2) ? col_ok : 3'b000};
    bits     = win_bits & in_image;
    if (r >= 1 && c >= 1) record_result(bits, 1, 1, r - 1, c - 1, 1'b0);
    if (r >= 1 && end_col) record_result(bits, 2, 1, r - 1, c, 1'b0);
    if (last_row && c >= 1) record_result(bits, 1, 2, r, c - 1, 1'b0);
    if (last_row && end_col) record_result(bits, 2, 2, r, c, 1'b1);
    if (end_col) begin
      next_col = 0;
      next_row = last_row ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  // Output side: random stalls, checked at each transfer
  always @(negedge clk_i) begin
    m_tready_i <= !gaps_on || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    mnc_pkg::res_t seen;
    mnc_pkg::res_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      seen = mnc_pkg::res_t'(m_tdata_o[$bits(mnc_pkg::res_t)-1:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got class %0d row %0d col %0d",
                 $time, seen.class_code, seen.pixel_row, seen.pixel_col);
      end else begin
        want = pending_results.pop_front();
        if (seen.class_code !== want.class_code || seen.pixel_row !== want.pixel_row ||
            seen.pixel_col !== want.pixel_col || seen.frame_done !== want.frame_done ||
            seen.poor_total !== want.poor_total || seen.bad_total !== want.bad_total) begin
          fail_count++;
          $display({"%0t: mismatch, expected class %0d row %0d col %0d done %0b ",
                    "poor %0d bad %0d, got class %0d row %0d col %0d done %0b ",
                    "poor %0d bad %0d"}, $time,
                   want.class_code, want.pixel_row, want.pixel_col, want.frame_done,
                   want.poor_total, want.bad_total,
                   seen.class_code, seen.pixel_row, seen.pixel_col, seen.frame_done,
                   seen.poor_total, seen.bad_total);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Entered and left at a falling edge; valid stays high across back-to-back pixels
  task automatic send_pixel(input logic [15:0] word);
    while (gaps_on && $urandom_range(99) < 13) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= word;
    do @(posedge clk_i); while (!s_tready_o);
    classify_pixel(word);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every queued result has come out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [mnc_pkg::CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      mnc_pkg::REG_FRAME_WIDTH:  frame_w = value[mnc_pkg::DIM_W-1:0];
      mnc_pkg::REG_FRAME_HEIGHT: frame_h = value[mnc_pkg::DIM_W-1:0];
      mnc_pkg::REG_MASK_SELECT:  select_bits = value[mnc_pkg::SEL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h,
                           input logic [15:0] sel);
    wait_idle();
    write_reg(mnc_pkg::REG_FRAME_WIDTH, mnc_pkg::CFG_W'(w));
    write_reg(mnc_pkg::REG_FRAME_HEIGHT, mnc_pkg::CFG_W'(h));
    write_reg(mnc_pkg::REG_MASK_SELECT, sel);
  endtask

  function automatic logic [15:0] random_select();
    case ($urandom_range(3))
      0:       return '1;
      1:       return '0;
      2:       return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Good words clear every selected bit; masked words set at least one
  function automatic logic [15:0] random_word(logic [15:0] sel, int unsigned good_pct);
    logic [15:0] raw;
    raw = 16'($urandom);
    if (sel == '0 || $urandom_range(99) < good_pct) return raw & ~sel;
    return raw | (sel & (~sel + 16'd1));
  endfunction

  // 1x1 frames: a lone good pixel and a lone masked one
  task automatic test_lone_pixel();
    set_frame(1, 1, 16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
  endtask

  // 3x3: masked center in a good ring, then masked center with only its
  // upper-left block good
  task automatic test_center_and_corner();
    set_frame(3, 3, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'h8000 : 16'h0000);
    set_frame(3, 3, 16'h0001);
    for (int i = 0; i < 9; i++)
      send_pixel((i == 0 || i == 1 || i == 3) ? 16'hFFFE : 16'h0001);
  endtask

  // Long single row, no bubbles on either side
  task automatic test_wide_row();
    logic [15:0] sel;
    sel = random_select();
    set_frame(ROW_PIXELS, 1, sel);
    gaps_on = 1'b0;
    for (int i = 0; i < ROW_PIXELS; i++) send_pixel(random_word(sel, 60));
    gaps_on = 1'b1;
  endtask

  // Single column, one pixel per row
  task automatic test_tall_column();
    logic [15:0] sel;
    sel = random_select();
    set_frame(1, COLUMN_PIXELS, sel);
    for (int i = 0; i < COLUMN_PIXELS; i++) send_pixel(random_word(sel, 70));
  endtask

  // Registers changed inside a frame: shrink the width past the current column and make
  // the current row the last, then swap the select mask halfway through the next frame
  task automatic test_live_reconfig();
    set_frame(6, 5, 16'h00F0);
    for (int i = 0; i < 15; i++) send_pixel(random_word(16'h00F0, 65));
    wait_idle();
    write_reg(mnc_pkg::REG_FRAME_WIDTH, mnc_pkg::CFG_W'(2));
    write_reg(mnc_pkg::REG_FRAME_HEIGHT, mnc_pkg::CFG_W'(3));
    send_pixel(random_word(16'h00F0, 65));
    for (int i = 0; i < 3; i++) send_pixel(random_word(16'h00F0, 65));
    wait_idle();
    write_reg(mnc_pkg::REG_MASK_SELECT, 16'h0F00);
    for (int i = 0; i < 3; i++) send_pixel(random_word(16'h0F00, 65));
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned pct;
    int unsigned stop_at;
    int unsigned hold_at;
    int unsigned room;
    logic [15:0] sel;
    stop_at = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < stop_at) begin
      room = stop_at - pixels_sent;
      w   = ($urandom_range(7) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
      h   = $urandom_range(1, 8);
      // keep whole frames inside the pixel budget
      if (w > room) w = room;
      if (w * h > room) h = room / w;
      sel = random_select();
      pct = $urandom_range(20, 95);
      set_frame(w, h, sel);
      hold_at = ($urandom_range(3) == 0) ? $urandom_range(1, w * h) : 0;
      for (int i = 0; i < w * h; i++) begin
        // sometimes drain the output completely in the middle of a frame
        if (hold_at != 0 && i == hold_at) wait_idle();
        send_pixel(random_word(sel, pct));
      end
    end
  endtask

  initial begin
    foreach (above_bits[i]) begin
      above_bits[i]  = 1'b0;
      above2_bits[i] = 1'b0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_lone_pixel();
    test_center_and_corner();
    test_wide_row();
    test_tall_column();
    test_live_reconfig();
    test_random_frames();
    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
